// File: rtl/scfc_pkg.sv
// Shared types and constants for the summed-checksum frame checker.
`default_nettype none

package scfc_pkg;

   localparam int BYTE_WIDTH     = 8;
   localparam int SUM_WIDTH      = 16;
   localparam int STATUS_WIDTH   = 3;
   localparam int CSR_IDX_WIDTH  = 8;
   localparam int FRAME_OVERHEAD = 11;
   localparam int RSP_DATA_WIDTH = 72;

   // Status codes, in priority order after ok
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK           = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SHORT        = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_PREAMBLE = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_START    = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_LENGTH_SHORT = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SUM_MISMATCH = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PREAMBLE_FIRST  = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PREAMBLE_SECOND = 8'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PREAMBLE_THIRD  = 8'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HEADER_START    = 8'd3;

   localparam logic [BYTE_WIDTH-1:0] RESET_PREAMBLE_FIRST  = 8'd255;
   localparam logic [BYTE_WIDTH-1:0] RESET_PREAMBLE_SECOND = 8'd0;
   localparam logic [BYTE_WIDTH-1:0] RESET_PREAMBLE_THIRD  = 8'd255;
   localparam logic [BYTE_WIDTH-1:0] RESET_HEADER_START    = 8'd165;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] preamble_first;
      logic [BYTE_WIDTH-1:0] preamble_second;
      logic [BYTE_WIDTH-1:0] preamble_third;
      logic [BYTE_WIDTH-1:0] header_start_value;
   } cfg_type;

   // Packed from status in the low bits up to received_sum
   typedef struct packed {
      logic [SUM_WIDTH-1:0]    received_sum;
      logic [SUM_WIDTH-1:0]    computed_sum;
      logic [BYTE_WIDTH-1:0]   payload_length;
      logic [BYTE_WIDTH-1:0]   action_code;
      logic [BYTE_WIDTH-1:0]   source_address;
      logic [BYTE_WIDTH-1:0]   dest_address;
      logic [STATUS_WIDTH-1:0] status;
   } result_type;

   localparam int RESULT_WIDTH = $bits(result_type);

endpackage

`default_nettype wire

// File: rtl/sum_checked_frame_checker_top.sv
// Top level of the summed-checksum frame checker: ports, registers, result stage.
`default_nettype none

// Takes one packet byte per beat, with tlast on the final byte, and returns
// one status beat per packet. A byte is taken every cycle while req_tready
// is high: the whole check and sum update for a byte is combinational logic
// ahead of the result register, and the status beat appears on rsp_ in the
// cycle after the final byte is accepted. req_tready drops only while a
// result is held and not taken. Checks are reported in this order: short,
// bad preamble, bad start byte, length short, checksum mismatch. The byte
// count saturates at POSITION_LIMIT. Registers on the csr_ port must be written
// only while idle; the block itself does not enforce this. An unknown index is ignored.
module sum_checked_frame_checker_top #(
   parameter int MIN_FRAME_BYTES = 11,
   parameter int POSITION_LIMIT  = 511
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tdata: data_byte[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   // tdata: status[2:0], dest_address[10:3], source_address[18:11],
   // action_code[26:19], payload_length[34:27], computed_sum[50:35],
   // received_sum[66:51], zero fill [71:67]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import scfc_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       req_beat;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_first     <= RESET_PREAMBLE_FIRST;
         cfg_ff.preamble_second    <= RESET_PREAMBLE_SECOND;
         cfg_ff.preamble_third     <= RESET_PREAMBLE_THIRD;
         cfg_ff.header_start_value <= RESET_HEADER_START;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PREAMBLE_FIRST:  cfg_ff.preamble_first     <= csr_data;
            CSR_PREAMBLE_SECOND: cfg_ff.preamble_second    <= csr_data;
            CSR_PREAMBLE_THIRD:  cfg_ff.preamble_third     <= csr_data;
            CSR_HEADER_START:    cfg_ff.header_start_value <= csr_data;
            default: begin
            end
         endcase
      end
   end

   scfc_frame_state #(
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES),
      .POSITION_LIMIT  (POSITION_LIMIT)
   ) u_frame_state (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_beat),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // Load on the final beat; hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_beat && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && req_tlast) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_WIDTH - RESULT_WIDTH)'(0), rsp_data_ff};

endmodule

`default_nettype wire

// File: rtl/scfc_frame_state.sv
// Per-packet tracking: byte count, header capture, running sum and status.
`default_nettype none

module scfc_frame_state #(
   parameter int MIN_FRAME_BYTES = 11,
   parameter int POSITION_LIMIT  = 511
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                beat_valid,
   input  wire logic [7:0]          data_byte,
   input  wire logic                final_byte,
   input  wire scfc_pkg::cfg_type   cfg,
   output scfc_pkg::result_type     result
);
   import scfc_pkg::*;

   localparam int PosWidth  = $clog2(POSITION_LIMIT + 1);
   localparam int WideWidth = PosWidth + 1;
   localparam logic [PosWidth-1:0]  PosLimit = PosWidth'(POSITION_LIMIT);
   localparam logic [WideWidth-1:0] MinFrame = WideWidth'(MIN_FRAME_BYTES);
   localparam logic [WideWidth-1:0] Overhead = WideWidth'(FRAME_OVERHEAD);
   localparam logic [WideWidth-1:0] LastHdr  = WideWidth'(8);

   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic                  preamble_good_ff, preamble_good_in;
   logic                  start_good_ff, start_good_in;
   logic [BYTE_WIDTH-1:0] dest_ff, dest_in;
   logic [BYTE_WIDTH-1:0] source_ff, source_in;
   logic [BYTE_WIDTH-1:0] action_ff, action_in;
   logic [BYTE_WIDTH-1:0] length_ff, length_in;
   logic [BYTE_WIDTH-1:0] prev_ff;

   logic                  saturated;
   logic                  in_sum_window;
   logic [PosWidth-1:0]   count;
   logic [SUM_WIDTH-1:0]  received;

   assign saturated     = pos_ff >= PosLimit;
   assign in_sum_window = (pos_ff >= PosWidth'(3)) &&
                          ({1'b0, pos_ff} <= LastHdr + WideWidth'(length_ff));
   assign count         = saturated ? PosLimit : pos_ff + PosWidth'(1);
   assign pos_in        = count;
   assign received      = {prev_ff, data_byte};

   // Fold in this byte; a saturated count freezes everything
   always_comb begin
      preamble_good_in = preamble_good_ff;
      start_good_in    = start_good_ff;
      dest_in          = dest_ff;
      source_in        = source_ff;
      action_in        = action_ff;
      length_in        = length_ff;
      sum_in           = sum_ff;
      if (!saturated) begin
         if (pos_ff == PosWidth'(0) && data_byte != cfg.preamble_first) begin
            preamble_good_in = 1'b0;
         end
         if (pos_ff == PosWidth'(1) && data_byte != cfg.preamble_second) begin
            preamble_good_in = 1'b0;
         end
         if (pos_ff == PosWidth'(2) && data_byte != cfg.preamble_third) begin
            preamble_good_in = 1'b0;
         end
         if (pos_ff == PosWidth'(3) && data_byte != cfg.header_start_value) begin
            start_good_in = 1'b0;
         end
         if (pos_ff == PosWidth'(5)) begin
            dest_in = data_byte;
         end
         if (pos_ff == PosWidth'(6)) begin
            source_in = data_byte;
         end
         if (pos_ff == PosWidth'(7)) begin
            action_in = data_byte;
         end
         if (pos_ff == PosWidth'(8)) begin
            length_in = data_byte;
         end
         if (in_sum_window) begin
            sum_in = sum_ff + SUM_WIDTH'(data_byte);
         end
      end
   end

   always_comb begin
      if ({1'b0, count} < MinFrame) begin
         result.status = STATUS_SHORT;
      end else if (!preamble_good_in) begin
         result.status = STATUS_BAD_PREAMBLE;
      end else if (!start_good_in) begin
         result.status = STATUS_BAD_START;
      end else if ({1'b0, count} < Overhead + WideWidth'(length_in)) begin
         result.status = STATUS_LENGTH_SHORT;
      end else if (sum_in != received) begin
         result.status = STATUS_SUM_MISMATCH;
      end else begin
         result.status = STATUS_OK;
      end
      result.dest_address   = dest_in;
      result.source_address = source_in;
      result.action_code    = action_in;
      result.payload_length = length_in;
      result.computed_sum   = sum_in;
      result.received_sum   = received;
   end

   // Clear all packet state after the final beat
   always_ff @(posedge clock) begin
      if (reset || (beat_valid && final_byte)) begin
         pos_ff           <= '0;
         sum_ff           <= '0;
         preamble_good_ff <= 1'b1;
         start_good_ff    <= 1'b1;
         dest_ff          <= '0;
         source_ff        <= '0;
         action_ff        <= '0;
         length_ff        <= '0;
         prev_ff          <= '0;
      end else if (beat_valid) begin
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         preamble_good_ff <= preamble_good_in;
         start_good_ff    <= start_good_in;
         dest_ff          <= dest_in;
         source_ff        <= source_in;
         action_ff        <= action_in;
         length_ff        <= length_in;
         prev_ff          <= data_byte;
      end
   end

endmodule

`default_nettype wire
